@@ src/fpw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpw_pkg: shared types and constants for the four-level page walk
// Store geometry, field widths, codes and the walk sequencer states.
// ----------------------------------------------------------------------------
package fpw_pkg;

  // Table store geometry
  localparam int STORE_WORDS = 4096;
  localparam int STORE_AW    = $clog2(STORE_WORDS);
  // Low byte-address bits that matter for store addressing (word index + 3)
  localparam int PTR_BITS    = STORE_AW + 3;

  // Virtual address layout
  localparam int INDEX_BITS  = 9;
  localparam int PAGE_SHIFT  = 12;
  localparam int NUM_LEVELS  = 4;
  localparam int VA_BITS     = NUM_LEVELS * INDEX_BITS;

  localparam logic [63:0] UNMAPPED_VALUE = 64'hDEAD;
  localparam logic [63:0] PAGE_MASK      = ~64'hFFF;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROOT_TABLE_ADDR   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIRECT_MAP_OFFSET = 1'b1;

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_XLATE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } walk_state_t;

  // Pick the table index of one level out of the 36 virtual page bits.
  function automatic logic [INDEX_BITS-1:0] level_index(
    input logic [VA_BITS-1:0] va,
    input logic [1:0]         lvl
  );
    logic [INDEX_BITS-1:0] idx;
    case (lvl)
      2'd0:    idx = va[0*INDEX_BITS +: INDEX_BITS];
      2'd1:    idx = va[1*INDEX_BITS +: INDEX_BITS];
      2'd2:    idx = va[2*INDEX_BITS +: INDEX_BITS];
      2'd3:    idx = va[3*INDEX_BITS +: INDEX_BITS];
      default: idx = '0;
    endcase
    return idx;
  endfunction

endpackage

@@ src/fpw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fpw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/four_level_page_walk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_walk: four-level page table walker over an internal store
// Loads table words and walks four levels of tables to translate addresses.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the 4096-word table store to zero, one
// word per cycle, and in_stall stays high until the sweep ends (configuration
// writes are taken during the sweep, cfg_ready is always high). A write item
// (in_mode = 0) stores in_data at word (in_address >> 3) mod 4096 and is
// acknowledged with one result in the next cycle. A translate item
// (in_mode = 1) issues the root read at acceptance and then reads the entry
// of each lower level on the single read port of the store, each address
// formed from the entry just read. A full walk takes four dependent store
// reads through one shared address unit. One item is in flight at a time;
// the result waits in an output register, and a new item is taken as that
// register drains. The walk ends at the leaf entry or at the first zero entry.
// Unmapped walks return mapped = 0 and 0xDEAD; a mapped walk returns the leaf
// entry with its low 12 bits cleared (bits 63:12 kept, page offset not added).
// ----------------------------------------------------------------------------
module four_level_page_walk
  import fpw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // Input item channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_mode,
  input  logic [63:0]             in_address,
  input  logic [63:0]             in_data,
  // Result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_was_translation,
  output logic                    out_mapped,
  output logic [63:0]             out_result_value,
  // Configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [63:0]             cfg_data
);

  localparam logic [PTR_BITS-1:0] PTR_PAGE_MASK = PAGE_MASK[PTR_BITS-1:0];

  // Sequencer state
  walk_state_t         state_r, state_nxt;
  logic [STORE_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [1:0]          lvl_r, lvl_nxt;
  logic [VA_BITS-1:0]  va_r, va_nxt;

  // Configuration; only the bits that address the store are kept
  logic [PTR_BITS-1:0] root_r;
  logic [PTR_BITS-1:0] dmo_r;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_xlate_r, out_xlate_nxt;
  logic        out_mapped_r, out_mapped_nxt;
  logic [63:0] out_value_r, out_value_nxt;

  // Store ports
  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [63:0]         ram_wdata;
  logic [STORE_AW-1:0] ram_raddr;
  logic [63:0]         ram_rdata;

  // Shared address unit
  logic [PTR_BITS-1:0]   tbl_base;
  logic [INDEX_BITS-1:0] tbl_idx;
  logic [PTR_BITS-1:0]   entry_addr;

  logic                  in_xfer;
  logic                  out_free;
  logic                  entry_zero;

  fpw_ram #(
    .WIDTH (64),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register is free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_xfer  = in_valid && !in_stall;

  assign entry_zero = (ram_rdata == 64'd0);

  // Entry address: table base plus eight times the level index, wrapping.
  // Idle: base is the root table. Walking: base is the entry just read,
  // page-aligned, plus the direct-map offset.
  always_comb begin
    if (state_r == ST_WALK) begin
      tbl_base = (ram_rdata[PTR_BITS-1:0] & PTR_PAGE_MASK) + dmo_r;
      tbl_idx  = level_index(va_r, lvl_r - 2'd1);
    end else begin
      tbl_base = root_r;
      tbl_idx  = level_index(in_address[PAGE_SHIFT +: VA_BITS], 2'd3);
    end
    entry_addr = tbl_base + PTR_BITS'({tbl_idx, 3'b000});
  end

  assign ram_raddr = entry_addr[PTR_BITS-1:3];

  // Next state and outputs of the walk sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    lvl_nxt        = lvl_r;
    va_nxt         = va_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_xlate_nxt  = out_xlate_r;
    out_mapped_nxt = out_mapped_r;
    out_value_nxt  = out_value_r;
    ram_we         = 1'b0;
    ram_waddr      = in_address[3 +: STORE_AW];
    ram_wdata      = in_data;

    case (state_r)
      ST_CLEAR: begin
        // Sweep the store to zero, one word per cycle
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = 64'd0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {STORE_AW{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          if (in_mode == MODE_WRITE) begin
            // Store the word and register the acknowledge
            ram_we         = 1'b1;
            out_valid_nxt  = 1'b1;
            out_xlate_nxt  = 1'b0;
            out_mapped_nxt = 1'b0;
            out_value_nxt  = 64'd0;
          end else begin
            // Root read goes out with the transfer; hold the page bits
            va_nxt    = in_address[PAGE_SHIFT +: VA_BITS];
            lvl_nxt   = 2'd3;
            state_nxt = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        // ram_rdata holds the entry of level lvl_r
        if (entry_zero) begin
          out_valid_nxt  = 1'b1;
          out_xlate_nxt  = 1'b1;
          out_mapped_nxt = 1'b0;
          out_value_nxt  = UNMAPPED_VALUE;
          state_nxt      = ST_IDLE;
        end else if (lvl_r == 2'd0) begin
          out_valid_nxt  = 1'b1;
          out_xlate_nxt  = 1'b1;
          out_mapped_nxt = 1'b1;
          out_value_nxt  = ram_rdata & PAGE_MASK;
          state_nxt      = ST_IDLE;
        end else begin
          // Next level read is already on the read port
          lvl_nxt = lvl_r - 2'd1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lvl_r        <= lvl_nxt;
    va_r         <= va_nxt;
    out_xlate_r  <= out_xlate_nxt;
    out_mapped_r <= out_mapped_nxt;
    out_value_r  <= out_value_nxt;
  end

  // Configuration registers, written whenever a transfer arrives
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
      dmo_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROOT_TABLE_ADDR:   root_r <= cfg_data[PTR_BITS-1:0];
        CFG_DIRECT_MAP_OFFSET: dmo_r  <= cfg_data[PTR_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_was_translation = out_xlate_r;
  assign out_mapped          = out_mapped_r;
  assign out_result_value    = out_value_r;

endmodule

@@ src/fpw_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpw_checker: port-level checks for the four-level page walk
// Watches the result channel for well-formed acknowledges and walk results.
// ----------------------------------------------------------------------------
module fpw_checker
  import fpw_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_was_translation,
  input logic        out_mapped,
  input logic [63:0] out_result_value
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value)
      && $stable(out_mapped) && $stable(out_was_translation))
    else $error("stalled result changed");

  // A write transfer is acknowledged in the next cycle
  a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == MODE_WRITE) |=> out_valid && !out_was_translation)
    else $error("write not acknowledged");

  a_ack_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_translation |-> !out_mapped && (out_result_value == 64'd0))
    else $error("bad write acknowledge");

  a_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_translation && !out_mapped |-> out_result_value == UNMAPPED_VALUE)
    else $error("unmapped result not 0xDEAD");

  a_mapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mapped |-> out_was_translation && (out_result_value[11:0] == 12'd0))
    else $error("mapped result not page aligned");

endmodule

bind four_level_page_walk fpw_checker u_fpw_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_mode             (in_mode),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_was_translation (out_was_translation),
  .out_mapped          (out_mapped),
  .out_result_value    (out_result_value)
);
